@@ rtl/text_crtc_offset_tracker_unit_assert.svh @@
// Assertion macros for the CRTC offset tracker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef TEXT_CRTC_OFFSET_TRACKER_UNIT_ASSERT_SVH
`define TEXT_CRTC_OFFSET_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication
`define TCOT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCOT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tcot_pkg.sv @@
// Shared types and codes for the CRTC offset tracker.
// No dependencies; used by tcot_decode and the top level.
package tcot_pkg;

    localparam logic [1:0] OP_INDEX = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_MEM   = 2'd2;

    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_SCROLL = 3'd1;
    localparam logic [2:0] EV_CURSOR = 3'd2;
    localparam logic [2:0] EV_UPDATE = 3'd3;
    localparam logic [2:0] EV_LENERR = 3'd4;

    localparam logic [7:0] REG_START_HI  = 8'h0C;
    localparam logic [7:0] REG_START_LO  = 8'h0D;
    localparam logic [7:0] REG_CURSOR_HI = 8'h0E;
    localparam logic [7:0] REG_CURSOR_LO = 8'h0F;

    // architectural CRTC state
    typedef struct packed {
        logic [7:0]  sel;
        logic [15:0] screen;
        logic [15:0] pending;
        logic [15:0] cursor;
    } tcot_state_t;

    // operands handed from the decode stage to the divide stages
    typedef struct packed {
        logic [2:0]  ev;
        logic        neg;   // sign of the line difference
        logic [15:0] mag;   // magnitude of the cell difference
        logic [15:0] opb;   // cursor cell or framebuffer cell index
        logic [12:0] left;  // clipped update length
    } tcot_op_t;

endpackage

@@ rtl/tcot_decode.sv @@
// Decode of one bus or memory word: next CRTC state and divider operands.
// Depends on tcot_pkg.
module tcot_decode
    import tcot_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic [1:0]  op,
    input  logic [15:0] bus_data,
    input  logic [12:0] access_length,
    input  logic [14:0] mem_offset,
    input  logic        attached,
    input  tcot_state_t st,
    output tcot_state_t st_next,
    output tcot_op_t    res
);

    localparam int SCREEN_BYTES = COLUMNS * ROWS * 2;
    localparam int POS_W        = $clog2(SCREEN_BYTES);
    localparam int LW           = (POS_W + 1 > 13) ? POS_W + 1 : 13;

    logic        wr_en;
    logic [7:0]  wr_idx;
    logic [7:0]  wr_val;
    logic [15:0] start_sum;
    logic [15:0] cur_sum;
    logic [16:0] start_diff;
    logic [16:0] cur_diff;
    logic [16:0] start_neg;
    logic [16:0] cur_neg;
    logic [16:0] base;
    logic [17:0] win_end;
    logic [17:0] off_w;
    logic [17:0] pos_full;
    logic [POS_W-1:0] pos;
    logic [POS_W:0]   left_full;
    logic [LW-1:0]    left_w;
    logic        in_win;
    logic [12:0] clipped;

    always_comb
    begin
        wr_en  = 1'b0;
        wr_idx = st.sel;
        wr_val = 8'h00;
        unique case (op)
            OP_INDEX:
            begin
                if (access_length == 13'd2)
                begin
                    wr_en  = 1'b1;
                    wr_idx = bus_data[7:0];
                    wr_val = bus_data[15:8];
                end
            end
            OP_DATA:
            begin
                if (access_length == 13'd1)
                begin
                    wr_en  = 1'b1;
                    wr_val = bus_data[7:0];
                end
            end
            default: ;
        endcase
    end

    assign start_sum  = st.pending + {8'h00, wr_val};
    assign cur_sum    = st.cursor + {8'h00, wr_val};
    assign start_diff = {1'b0, start_sum} - {1'b0, st.screen};
    assign cur_diff   = {1'b0, cur_sum} - {1'b0, st.screen};
    assign start_neg  = 17'd0 - start_diff;
    assign cur_neg    = 17'd0 - cur_diff;

    // visible window in bytes starts at twice the start cell
    assign base      = {st.screen, 1'b0};
    assign win_end   = {1'b0, base} + 18'(SCREEN_BYTES);
    assign off_w     = {3'b000, mem_offset};
    assign in_win    = (off_w >= {1'b0, base}) && (off_w < win_end);
    assign pos_full  = off_w - {1'b0, base};
    assign pos       = pos_full[POS_W-1:0];
    assign left_full = (POS_W + 1)'(SCREEN_BYTES) - {1'b0, pos};
    assign left_w    = LW'(left_full);
    assign clipped   = (LW'(access_length) < left_w) ? access_length : left_w[12:0];

    always_comb
    begin
        st_next = st;
        res     = '0;
        unique case (op)
            OP_INDEX:
            begin
                if (access_length > 13'd2)
                    res.ev = EV_LENERR;
                else
                    st_next.sel = bus_data[7:0];
            end
            OP_DATA:
            begin
                if (access_length != 13'd1)
                    res.ev = EV_LENERR;
            end
            OP_MEM:
            begin
                if (in_win && attached)
                begin
                    res.ev   = EV_UPDATE;
                    res.opb  = 16'(pos[POS_W-1:1]);
                    res.left = clipped;
                end
            end
            default: ;
        endcase

        if (wr_en)
        begin
            unique case (wr_idx)
                REG_START_HI:
                    st_next.pending = {wr_val, 8'h00};
                REG_START_LO:
                begin
                    st_next.screen  = start_sum;
                    st_next.pending = 16'h0000;
                    if (attached)
                    begin
                        res.ev  = EV_SCROLL;
                        res.neg = start_diff[16];
                        res.mag = start_diff[16] ? start_neg[15:0] : start_diff[15:0];
                    end
                end
                REG_CURSOR_HI:
                    st_next.cursor = {wr_val, 8'h00};
                REG_CURSOR_LO:
                begin
                    st_next.cursor = cur_sum;
                    if (attached)
                    begin
                        res.ev  = EV_CURSOR;
                        res.neg = cur_diff[16];
                        res.mag = cur_diff[16] ? cur_neg[15:0] : cur_diff[15:0];
                        res.opb = cur_sum;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/text_crtc_offset_tracker_unit.sv @@
// CRTC start-address / cursor tracker top level: stream ports, state and divide pipeline.
// Depends on tcot_pkg, tcot_decode and text_crtc_offset_tracker_unit_assert.svh.
//
// Every accepted word yields exactly one result word, and a new word is accepted every
// cycle unless the output stalls and every stage is full. The four stages are the
// input register, the decode stage that updates the CRTC state and the window check,
// the reciprocal multiply that divides by the column count, and the remainder stage
// that forms columns and signed rows. State updates all happen in the decode stage,
// so back-to-back words see each other's effects. No clearing pass after reset.
`include "text_crtc_offset_tracker_unit_assert.svh"

module text_crtc_offset_tracker_unit
    import tcot_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_data,    // console_attached
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,     // bus_data[15:0], access_length[28:16], mem_offset[43:29]
    input  logic [1:0]  s_tuser,     // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,     // scroll_lines[10:0], cursor_col[17:11],
                                     // cursor_row[28:18], update_col[35:29],
                                     // update_row[40:36], update_length[52:41]
    output logic [2:0]  m_tuser      // event_res[2:0]
);

    localparam int SHIFT     = 24;
    localparam int RECIP_VAL = ((1 << SHIFT) + COLUMNS - 1) / COLUMNS;
    localparam int RECIP_W   = $clog2(RECIP_VAL + 1);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

    logic        attached_reg;
    tcot_state_t st_reg;
    tcot_state_t st_next;

    logic        v0_reg, v1_reg, v2_reg, v3_reg;
    logic        ready1, ready2, ready3;

    logic [1:0]  op0_reg;
    logic [15:0] data0_reg;
    logic [12:0] len0_reg;
    logic [14:0] off0_reg;

    tcot_op_t    dec_res;
    tcot_op_t    op1_reg;

    logic [15+RECIP_W:0] prod_a;
    logic [15+RECIP_W:0] prod_b;
    logic [2:0]  ev2_reg;
    logic        neg2_reg;
    logic [15:0] qa2_reg;
    logic [15:0] qb2_reg;
    logic [15:0] opb2_reg;
    logic [12:0] left2_reg;

    logic [15:0] qb_cols;
    logic [6:0]  rem_b;
    logic [15:0] qa_neg;
    logic [15:0] qa_signed;
    logic [55:0] tdata_next;

    logic [2:0]  tuser_reg;
    logic [55:0] tdata_reg;

    assign ready3   = !v3_reg || m_tready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign s_tready = !v0_reg || ready1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            attached_reg <= 1'b0;
        else if (cfg_we)
            attached_reg <= cfg_data;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (s_tready)
            v0_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            op0_reg   <= s_tuser;
            data0_reg <= s_tdata[15:0];
            len0_reg  <= s_tdata[28:16];
            off0_reg  <= s_tdata[43:29];
        end
    end

    tcot_decode #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_decode (
        .op            (op0_reg),
        .bus_data      (data0_reg),
        .access_length (len0_reg),
        .mem_offset    (off0_reg),
        .attached      (attached_reg),
        .st            (st_reg),
        .st_next       (st_next),
        .res           (dec_res)
    );

    // decode stage: commit state as the word moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
            v1_reg <= 1'b0;
        end
        else if (ready1)
        begin
            v1_reg <= v0_reg;
            if (v0_reg)
                st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && v0_reg)
            op1_reg <= dec_res;
    end

    // reciprocal multiply, exact for 16-bit dividends
    assign prod_a = op1_reg.mag * RECIP;
    assign prod_b = op1_reg.opb * RECIP;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (ready2)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ready2 && v1_reg)
        begin
            ev2_reg   <= op1_reg.ev;
            neg2_reg  <= op1_reg.neg;
            qa2_reg   <= 16'(prod_a >> SHIFT);
            qb2_reg   <= 16'(prod_b >> SHIFT);
            opb2_reg  <= op1_reg.opb;
            left2_reg <= op1_reg.left;
        end
    end

    // remainder and sign restore
    assign qb_cols   = 16'(32'(qb2_reg) * COLUMNS);
    assign rem_b     = 7'(opb2_reg - qb_cols);
    assign qa_neg    = 16'd0 - qa2_reg;
    assign qa_signed = neg2_reg ? qa_neg : qa2_reg;

    always_comb
    begin
        tdata_next = '0;
        unique case (ev2_reg)
            EV_SCROLL:
                tdata_next[10:0] = qa_signed[10:0];
            EV_CURSOR:
            begin
                tdata_next[17:11] = rem_b;
                tdata_next[28:18] = qa_signed[10:0];
            end
            EV_UPDATE:
            begin
                tdata_next[35:29] = rem_b;
                tdata_next[40:36] = qb2_reg[4:0];
                tdata_next[52:41] = left2_reg[11:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (ready3)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ready3 && v2_reg)
        begin
            tuser_reg <= ev2_reg;
            tdata_reg <= tdata_next;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

    `TCOT_ASSERT_NEXT(a_accept_lands, s_tvalid && s_tready, v0_reg, "accepted word not held")
    `TCOT_ASSERT_IMPL(a_stall_full, !s_tready, v0_reg && v1_reg && v2_reg && v3_reg && !m_tready, "input stalled with a free stage")
    `TCOT_ASSERT_IMPL(a_none_zero, m_tvalid && m_tuser == EV_NONE, m_tdata == 56'd0, "empty event carries data")
    `TCOT_ASSERT_IMPL(a_row_range, m_tvalid && m_tuser == EV_UPDATE, 32'(m_tdata[40:36]) < ROWS, "update row outside screen")

endmodule
